// ===== hdl/pug_pkg.sv =====
// pug_pkg: shared types and constants of the phase unwrap / glitch smoother.
// Used by pug_ctrl, pug_dp and pug_div. No dependencies.
package pug_pkg;

    localparam int PH_W  = 19;      // phase word width
    localparam int NUM_W = 26;      // ramp numerator width (19 bit num times up to 64, plus half)
    localparam int DEN_W = 7;       // ramp denominator width (up to 64)

    localparam logic signed [19:0] DEG180 = 20'sd46080;
    localparam logic signed [19:0] DEG360 = 20'sd92160;
    localparam logic signed [20:0] PH_MAX = 21'sd262143;
    localparam logic signed [20:0] PH_MIN = -21'sd262144;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_U_RDA,
        OP_U_RDB,
        OP_U_CHK,
        OP_SRCH_RD,
        OP_U_SRCH_EV,
        OP_U_FIX_INIT,
        OP_U_FIX_RD,
        OP_U_FIX_WR,
        OP_U_NEXT,
        OP_S_RD0,
        OP_S_CHK,
        OP_S_SRCH_EV,
        OP_E_INIT,
        OP_R_ACC,
        OP_R_DIV,
        OP_R_WR,
        OP_E_RD,
        OP_E_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic load_full;    // accepted word closes the block
        logic s_done;       // unwrap walk finished
        logic jump;         // current step exceeds half a turn
        logic search_end;   // forward search index past its limit
        logic rev;          // reversing jump found
        logic fix_en;       // a correction span is pending
        logic span_done;    // index reached end of span
        logic smooth_go;    // small backward step at block start
        logic smooth_hit;   // recovery sample found
        logic div_done;     // ramp quotient ready
        logic emit_last;    // word on output is last of block
    } t_stat;

endpackage

// ===== hdl/pug_div.sv =====
// pug_div: restoring divider, one quotient bit per cycle, for the ramp samples.
// Depends on pug_pkg for widths.
module pug_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pug_pkg::NUM_W-1:0]    i_numer,
    input  logic [pug_pkg::DEN_W-1:0]    i_denom,
    output logic                         o_done,
    output logic [pug_pkg::NUM_W-1:0]    o_quot
);

    localparam int CNTW = $clog2(pug_pkg::NUM_W + 1);

    logic [pug_pkg::DEN_W:0]   r_rem;
    logic [pug_pkg::DEN_W-1:0] r_den;
    logic [pug_pkg::NUM_W-1:0] r_q;
    logic [CNTW-1:0]           r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [pug_pkg::DEN_W:0]   shift;
    logic                      ge;

    assign shift = {r_rem[pug_pkg::DEN_W-1:0], r_q[pug_pkg::NUM_W-1]};
    assign ge    = shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(pug_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_denom;
            r_q   <= i_numer;
        end else if (r_busy) begin
            r_rem <= ge ? (shift - {1'b0, r_den}) : shift;
            r_q   <= {r_q[pug_pkg::NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hdl/pug_dp.sv =====
// pug_dp: datapath: sample memory, block registers, unwrap/smooth arithmetic, output.
// Depends on pug_pkg and pug_div; driven by commands from pug_ctrl.
module pug_dp #(
    parameter int BLOCK_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pug_pkg::t_cmd                  i_cmd,
    output pug_pkg::t_stat                 o_stat,
    input  logic signed [pug_pkg::PH_W-1:0] i_phase_in,
    input  logic                           i_is_last,
    input  logic                           i_cfg_we,
    input  logic [5:0]                     i_cfg_wdata,
    output logic                           o_strobe,
    output logic signed [pug_pkg::PH_W-1:0] o_phase_out,
    output logic                           o_out_last
);

    localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
    localparam int CW = $clog2(BLOCK_DEPTH + 1);
    localparam int IW = CW + 1;
    localparam int SW = ((IW > 6) ? IW : 6) + 1;

    function automatic logic signed [pug_pkg::PH_W-1:0] sat19(input logic signed [20:0] v);
        logic signed [pug_pkg::PH_W-1:0] r;
        if (v > pug_pkg::PH_MAX) begin
            r = pug_pkg::PH_MAX[pug_pkg::PH_W-1:0];
        end else if (v < pug_pkg::PH_MIN) begin
            r = pug_pkg::PH_MIN[pug_pkg::PH_W-1:0];
        end else begin
            r = v[pug_pkg::PH_W-1:0];
        end
        return r;
    endfunction

    logic signed [pug_pkg::PH_W-1:0] mem [BLOCK_DEPTH];
    logic signed [pug_pkg::PH_W-1:0] r_rdata;

    logic [CW-1:0]                   r_n;
    logic signed [pug_pkg::PH_W-1:0] r_prev;
    logic [5:0]                      r_gl;
    logic [IW-1:0]                   r_s, r_k, r_end, r_maxi;
    logic signed [pug_pkg::PH_W-1:0] r_a, r_p, r_b;
    logic                            r_up, r_fix;
    logic [pug_pkg::NUM_W-1:0]       r_acc;

    logic                            rd_en, we;
    logic [IW-1:0]                   rd_addr, wr_addr;
    logic signed [pug_pkg::PH_W-1:0] wr_data;

    logic [IW-1:0]                   n_ext, n_m1, k_p1;
    logic signed [19:0]              d_cur, d_srch, d0;
    logic                            jump_cur, jump_srch, rev, smooth_go, hit1, hit2;
    logic signed [20:0]              xp, fixsum, rampsum;
    logic signed [pug_pkg::PH_W-1:0] hitval;
    logic signed [19:0]              diff;
    logic [pug_pkg::NUM_W-1:0]       num, numer, quot;
    logic [pug_pkg::DEN_W-1:0]       den;
    logic [SW-1:0]                   sg_sum;
    logic [IW-1:0]                   down_max, gl_lim;
    logic                            div_start, div_done;

    assign n_ext = IW'(r_n);
    assign n_m1  = n_ext - IW'(1);
    assign k_p1  = r_k + IW'(1);

    assign d_cur     = 20'(r_rdata) - 20'(r_a);
    assign jump_cur  = (d_cur > pug_pkg::DEG180) || (d_cur < -pug_pkg::DEG180);
    assign d_srch    = 20'(r_rdata) - 20'(r_p);
    assign jump_srch = (d_srch > pug_pkg::DEG180) || (d_srch < -pug_pkg::DEG180);
    assign rev       = jump_srch && ((d_srch > 20'sd0) != r_up);

    assign d0        = 20'(r_rdata) - 20'(r_prev);
    assign smooth_go = (d0 < 20'sd0) && (d0 > -pug_pkg::DEG180);
    assign hit1      = r_rdata > r_prev;
    assign xp        = 21'(r_rdata) + 21'(pug_pkg::DEG360);
    assign hit2      = (d_srch < -pug_pkg::DEG180) && (xp > 21'(r_prev));
    assign hitval    = hit1 ? r_rdata : sat19(xp);

    assign fixsum  = r_up ? (21'(r_rdata) - 21'(pug_pkg::DEG360))
                          : (21'(r_rdata) + 21'(pug_pkg::DEG360));

    assign diff    = 20'(r_b) - 20'(r_prev);
    assign num     = (diff > 20'sd0) ? pug_pkg::NUM_W'(diff[pug_pkg::PH_W-1:0]) : '0;
    assign den     = pug_pkg::DEN_W'(r_end + IW'(1));
    assign numer   = r_acc + pug_pkg::NUM_W'(den >> 1);
    assign rampsum = 21'(r_prev) + $signed({1'b0, quot[19:0]});

    assign sg_sum   = SW'(r_s) + SW'(r_gl);
    assign down_max = (sg_sum < SW'(n_m1)) ? IW'(sg_sum) : n_m1;
    assign gl_lim   = (IW'(r_gl) < n_m1) ? IW'(r_gl) : n_m1;

    pug_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (numer),
        .i_denom (den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // memory access decode
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_k;
        we        = 1'b0;
        wr_addr   = r_k;
        wr_data   = sat19(fixsum);
        div_start = 1'b0;
        case (i_cmd.op)
            pug_pkg::OP_LOAD: begin
                we      = 1'b1;
                wr_addr = n_ext;
                wr_data = i_phase_in;
            end
            pug_pkg::OP_U_RDA: begin
                rd_en   = 1'b1;
                rd_addr = r_s - IW'(1);
            end
            pug_pkg::OP_U_RDB: begin
                rd_en   = 1'b1;
                rd_addr = r_s;
            end
            pug_pkg::OP_SRCH_RD, pug_pkg::OP_U_FIX_RD, pug_pkg::OP_E_RD: begin
                rd_en = 1'b1;
            end
            pug_pkg::OP_S_RD0: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            pug_pkg::OP_U_FIX_WR: begin
                we = 1'b1;
            end
            pug_pkg::OP_S_SRCH_EV: begin
                we      = hit2 && !hit1;
                wr_data = hitval;
            end
            pug_pkg::OP_R_DIV: begin
                div_start = 1'b1;
            end
            pug_pkg::OP_R_WR: begin
                we      = 1'b1;
                wr_data = sat19(rampsum);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr[AW-1:0]];
        end
    end

    // block control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_prev <= '0;
            r_gl   <= 6'(BLOCK_DEPTH - 1);
        end else begin
            if (i_cfg_we) begin
                r_gl <= i_cfg_wdata;
            end
            if (i_cmd.op == pug_pkg::OP_LOAD) begin
                r_n <= r_n + CW'(1);
            end
            if ((i_cmd.op == pug_pkg::OP_E_OUT) && o_out_last) begin
                r_prev <= r_rdata;
                r_n    <= '0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pug_pkg::OP_LOAD: begin
                r_s <= '0;
            end
            pug_pkg::OP_U_RDB: begin
                r_a <= (r_s == '0) ? r_prev : r_rdata;
            end
            pug_pkg::OP_U_CHK: begin
                if (jump_cur) begin
                    r_up   <= d_cur > 20'sd0;
                    r_fix  <= d_cur > 20'sd0;
                    r_maxi <= (d_cur > 20'sd0) ? n_m1 : down_max;
                    r_k    <= r_s + IW'(1);
                    r_p    <= r_rdata;
                    r_end  <= n_ext;
                end else begin
                    r_s <= r_s + IW'(1);
                end
            end
            pug_pkg::OP_U_SRCH_EV: begin
                if (rev) begin
                    r_end <= r_k;
                    r_fix <= 1'b1;
                end else begin
                    r_p <= r_rdata;
                    r_k <= k_p1;
                end
            end
            pug_pkg::OP_U_FIX_INIT: begin
                r_k <= r_s;
            end
            pug_pkg::OP_U_FIX_WR, pug_pkg::OP_R_WR: begin
                r_k <= k_p1;
            end
            pug_pkg::OP_U_NEXT: begin
                r_s <= r_fix ? (r_end + IW'(1)) : (r_s + IW'(1));
            end
            pug_pkg::OP_S_CHK: begin
                r_p    <= r_rdata;
                r_k    <= smooth_go ? IW'(1) : '0;
                r_maxi <= gl_lim;
            end
            pug_pkg::OP_S_SRCH_EV: begin
                if (hit1 || hit2) begin
                    r_b   <= hitval;
                    r_end <= r_k;
                    r_k   <= '0;
                    r_acc <= '0;
                end else begin
                    r_p <= r_rdata;
                    r_k <= k_p1;
                end
            end
            pug_pkg::OP_E_INIT: begin
                r_k <= '0;
            end
            pug_pkg::OP_R_ACC: begin
                r_acc <= r_acc + num;
            end
            pug_pkg::OP_E_OUT: begin
                r_k <= k_p1;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.load_full  = i_is_last || ((r_n + CW'(1)) == CW'(BLOCK_DEPTH));
    assign o_stat.s_done     = r_s >= n_m1;
    assign o_stat.jump       = jump_cur;
    assign o_stat.search_end = r_k > r_maxi;
    assign o_stat.rev        = rev;
    assign o_stat.fix_en     = r_fix;
    assign o_stat.span_done  = r_k >= r_end;
    assign o_stat.smooth_go  = smooth_go;
    assign o_stat.smooth_hit = hit1 || hit2;
    assign o_stat.div_done   = div_done;
    assign o_stat.emit_last  = r_k == n_m1;

    assign o_strobe    = i_cmd.op == pug_pkg::OP_E_OUT;
    assign o_phase_out = r_rdata;
    assign o_out_last  = r_k == n_m1;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(BLOCK_DEPTH))
        else $error("fill count beyond buffer depth");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out_last) |=> (r_n == '0))
        else $error("fill count not cleared after last word");
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_k < n_ext))
        else $error("emit index outside block");
`endif

endmodule

// ===== hdl/pug_ctrl.sv =====
// pug_ctrl: sequencer for load, unwrap, start smoothing, ramp and emit passes.
// Depends on pug_pkg; issues commands to pug_dp and reads its status.
module pug_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pug_pkg::t_stat i_stat,
    output pug_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    typedef enum logic [18:0] {
        ST_IDLE    = 19'd1,
        ST_U_TOP   = 19'd1 << 1,
        ST_U_RDB   = 19'd1 << 2,
        ST_U_CHK   = 19'd1 << 3,
        ST_U_SRCH  = 19'd1 << 4,
        ST_U_SRCHW = 19'd1 << 5,
        ST_U_FIXI  = 19'd1 << 6,
        ST_U_FIX   = 19'd1 << 7,
        ST_U_FIXW  = 19'd1 << 8,
        ST_U_NEXT  = 19'd1 << 9,
        ST_S_RD0   = 19'd1 << 10,
        ST_S_CHK   = 19'd1 << 11,
        ST_S_SRCH  = 19'd1 << 12,
        ST_S_SRCHW = 19'd1 << 13,
        ST_R_TOP   = 19'd1 << 14,
        ST_R_DIV   = 19'd1 << 15,
        ST_R_WAIT  = 19'd1 << 16,
        ST_E_RD    = 19'd1 << 17,
        ST_E_OUT   = 19'd1 << 18
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = pug_pkg::OP_NOP;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = pug_pkg::OP_LOAD;
                    if (i_stat.load_full) begin
                        n_state = ST_U_TOP;
                    end
                end
            end
            ST_U_TOP: begin
                if (i_stat.s_done) begin
                    n_state = ST_S_RD0;
                end else begin
                    o_cmd.op = pug_pkg::OP_U_RDA;
                    n_state  = ST_U_RDB;
                end
            end
            ST_U_RDB: begin
                o_cmd.op = pug_pkg::OP_U_RDB;
                n_state  = ST_U_CHK;
            end
            ST_U_CHK: begin
                o_cmd.op = pug_pkg::OP_U_CHK;
                n_state  = i_stat.jump ? ST_U_SRCH : ST_U_TOP;
            end
            ST_U_SRCH: begin
                if (i_stat.search_end) begin
                    n_state = ST_U_FIXI;
                end else begin
                    o_cmd.op = pug_pkg::OP_SRCH_RD;
                    n_state  = ST_U_SRCHW;
                end
            end
            ST_U_SRCHW: begin
                o_cmd.op = pug_pkg::OP_U_SRCH_EV;
                n_state  = i_stat.rev ? ST_U_FIXI : ST_U_SRCH;
            end
            ST_U_FIXI: begin
                o_cmd.op = pug_pkg::OP_U_FIX_INIT;
                n_state  = i_stat.fix_en ? ST_U_FIX : ST_U_NEXT;
            end
            ST_U_FIX: begin
                if (i_stat.span_done) begin
                    n_state = ST_U_NEXT;
                end else begin
                    o_cmd.op = pug_pkg::OP_U_FIX_RD;
                    n_state  = ST_U_FIXW;
                end
            end
            ST_U_FIXW: begin
                o_cmd.op = pug_pkg::OP_U_FIX_WR;
                n_state  = ST_U_FIX;
            end
            ST_U_NEXT: begin
                o_cmd.op = pug_pkg::OP_U_NEXT;
                n_state  = ST_U_TOP;
            end
            ST_S_RD0: begin
                o_cmd.op = pug_pkg::OP_S_RD0;
                n_state  = ST_S_CHK;
            end
            ST_S_CHK: begin
                o_cmd.op = pug_pkg::OP_S_CHK;
                n_state  = i_stat.smooth_go ? ST_S_SRCH : ST_E_RD;
            end
            ST_S_SRCH: begin
                if (i_stat.search_end) begin
                    o_cmd.op = pug_pkg::OP_E_INIT;
                    n_state  = ST_E_RD;
                end else begin
                    o_cmd.op = pug_pkg::OP_SRCH_RD;
                    n_state  = ST_S_SRCHW;
                end
            end
            ST_S_SRCHW: begin
                o_cmd.op = pug_pkg::OP_S_SRCH_EV;
                n_state  = i_stat.smooth_hit ? ST_R_TOP : ST_S_SRCH;
            end
            ST_R_TOP: begin
                if (i_stat.span_done) begin
                    o_cmd.op = pug_pkg::OP_E_INIT;
                    n_state  = ST_E_RD;
                end else begin
                    o_cmd.op = pug_pkg::OP_R_ACC;
                    n_state  = ST_R_DIV;
                end
            end
            ST_R_DIV: begin
                o_cmd.op = pug_pkg::OP_R_DIV;
                n_state  = ST_R_WAIT;
            end
            ST_R_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = pug_pkg::OP_R_WR;
                    n_state  = ST_R_TOP;
                end
            end
            ST_E_RD: begin
                o_cmd.op = pug_pkg::OP_E_RD;
                n_state  = ST_E_OUT;
            end
            ST_E_OUT: begin
                o_cmd.op = pug_pkg::OP_E_OUT;
                n_state  = i_stat.emit_last ? ST_IDLE : ST_E_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != ST_IDLE;

endmodule

// ===== hdl/phase_unwrap_glitch_smoother.sv =====
// phase_unwrap_glitch_smoother: top level, joins the sequencer and the datapath.
// Depends on pug_pkg, pug_ctrl, pug_dp (with pug_div).
//
//   channel   ports                                 handshake
//   input     i_phase_in, i_is_last                 start & !busy
//   result    o_phase_out, o_out_last               o_strobe, one cycle
//   config    i_cfg_wdata (glitch limit)            i_cfg_we
//
// While the block fills, one word is taken each cycle that start is high; busy
// stays low until the word that ends the block (is_last, or buffer full) is taken.
// Then the sequencer walks the sample memory: unwrap checks read two samples,
// searched samples are read and evaluated, corrected ones read and rewritten, ramp
// samples summed, divided (one-bit-per-cycle divider), written; words read, shown.
// Reset clears fill count, previous phase and the glitch limit (to depth minus one).
// The receiver cannot stall; each result word is shown for exactly one cycle.
module phase_unwrap_glitch_smoother #(
    parameter int BLOCK_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [pug_pkg::PH_W-1:0] i_phase_in,
    input  logic                            i_is_last,
    input  logic                            i_cfg_we,
    input  logic [5:0]                      i_cfg_wdata,
    output logic                            o_strobe,
    output logic signed [pug_pkg::PH_W-1:0] o_phase_out,
    output logic                            o_out_last
);

    pug_pkg::t_cmd  cmd;
    pug_pkg::t_stat stat;

    pug_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pug_dp #(
        .BLOCK_DEPTH (BLOCK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_phase_in  (i_phase_in),
        .i_is_last   (i_is_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_phase_out (o_phase_out),
        .o_out_last  (o_out_last)
    );

endmodule

// ===== test/tb_phase_unwrap_glitch_smoother.sv =====
// tb_phase_unwrap_glitch_smoother: self-checking bench for the phase unwrap and
// glitch smoother. Predicts each corrected block in the bench, checks every word.
// Depends on pug_pkg and phase_unwrap_glitch_smoother.
`timescale 1ns / 100ps

module tb_phase_unwrap_glitch_smoother;

    localparam int PW         = pug_pkg::PH_W;
    localparam int DEPTH      = 64;
    localparam int HALF_TURN  = 46080;
    localparam int FULL_TURN  = 92160;
    localparam int SETTLE     = 40;
    localparam int CYCLE_CAP  = 3000000;

    typedef struct {
        logic signed [PW-1:0] phase;
        logic                 last;
    } t_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [PW-1:0] i_phase_in;
    logic                 i_is_last;
    logic                 i_cfg_we;
    logic [5:0]           i_cfg_wdata;
    logic                 o_strobe;
    logic signed [PW-1:0] o_phase_out;
    logic                 o_out_last;

    // predictor state
    int    blk_buf [DEPTH];
    int    fill_cnt;
    int    held_phase;
    int    limit_reg;
    t_word corrected_q [$];

    int  err_cnt;
    int  cyc_cnt;
    bit  gaps_on;

    phase_unwrap_glitch_smoother #(.BLOCK_DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_phase_in  (i_phase_in),
        .i_is_last   (i_is_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_phase_out (o_phase_out),
        .o_out_last  (o_out_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int sat_phase(int v);
        if (v > 262143) return 262143;
        if (v < -262144) return -262144;
        return v;
    endfunction

    function automatic void unwrap_blk(int n, int prev, int gl);
        int s, c, i, d, d2, e, mx;
        bit up;
        for (s = 0; s < n - 1; s++) begin
            d = blk_buf[s] - (s == 0 ? prev : blk_buf[s-1]);
            if (d > HALF_TURN || d < -HALF_TURN) begin
                up = d > 0;
                if (!up) begin
                    e  = -1;
                    mx = s + gl;
                    if (mx > n - 1) mx = n - 1;
                end else begin
                    e  = n;
                    mx = n - 1;
                end
                for (c = s + 1; c <= mx; c++) begin
                    d2 = blk_buf[c] - blk_buf[c-1];
                    if ((d2 > HALF_TURN || d2 < -HALF_TURN) && ((d2 > 0) != up)) begin
                        e = c;
                        break;
                    end
                end
                for (i = s; i < e; i++)
                    blk_buf[i] = sat_phase(blk_buf[i] + (up ? -FULL_TURN : FULL_TURN));
                if (e > -1) s = e;
            end
        end
    endfunction

    function automatic void smooth_start(int n, int prev, int gl);
        int lim, d, e, i, num, den;
        lim = gl < n - 1 ? gl : n - 1;
        d   = blk_buf[0] - prev;
        e   = -1;
        if (!(d < 0 && d > -HALF_TURN)) return;
        for (i = 1; i <= lim; i++) begin
            if (blk_buf[i] > prev) begin
                e = i;
                break;
            end
            if (blk_buf[i] - blk_buf[i-1] < -HALF_TURN && blk_buf[i] + FULL_TURN > prev) begin
                blk_buf[i] = sat_phase(blk_buf[i] + FULL_TURN);
                e = i;
                break;
            end
        end
        if (e != -1) begin
            num = blk_buf[e] - prev;
            if (num < 0) num = 0;
            den = e + 1;
            for (i = 0; i < e; i++)
                blk_buf[i] = sat_phase(prev + (num * (i + 1) + den / 2) / den);
        end
    endfunction

    // accepted input word: store it, and correct the block once it closes
    function automatic void predict_word(logic signed [PW-1:0] ph, logic lst);
        int    k;
        t_word w;
        if (fill_cnt >= DEPTH) fill_cnt = 0;
        blk_buf[fill_cnt] = int'(ph);
        fill_cnt++;
        if (!lst && fill_cnt < DEPTH) return;
        unwrap_blk(fill_cnt, held_phase, limit_reg);
        smooth_start(fill_cnt, held_phase, limit_reg);
        held_phase = blk_buf[fill_cnt-1];
        for (k = 0; k < fill_cnt; k++) begin
            w.phase = blk_buf[k][PW-1:0];
            w.last  = (k == fill_cnt - 1);
            corrected_q.push_back(w);
        end
        fill_cnt = 0;
    endfunction

    always @(posedge i_clk) begin
        t_word w;
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_CAP) begin
            $display("phase_unwrap_glitch_smoother: mismatch");
            $finish;
        end else if (i_rst_n && o_strobe) begin
            if (corrected_q.size() == 0) begin
                $error("unexpected word: phase_out %0d", o_phase_out);
                err_cnt++;
            end else begin
                w = corrected_q.pop_front();
                if (o_phase_out !== w.phase) begin
                    $error("phase_out expected %0d actual %0d", w.phase, o_phase_out);
                    err_cnt++;
                end
                if (o_out_last !== w.last) begin
                    $error("out_last expected %0d actual %0d", w.last, o_out_last);
                    err_cnt++;
                end
            end
        end
    end

    // called just after a rising edge
    task automatic send_word(logic signed [PW-1:0] ph, logic lst);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_phase_in <= ph;
        i_is_last  <= lst;
        do @(posedge i_clk); while (busy);
        predict_word(ph, lst);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (corrected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [5:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_reg = v;
    endtask

    // block of n words near the held phase, with wraps, glitches, start dips
    task automatic send_block(int n);
        int  k, v, flip_at, flip_len;
        bit  noise;
        noise    = ($urandom_range(0, 7) == 0);
        v        = held_phase;
        flip_at  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : -1;
        flip_len = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
            if (k == 0 && $urandom_range(0, 2) == 0)
                v = v - $urandom_range(1, 46000);
            else
                v = v + $signed($urandom_range(0, 6000)) - 2000;
            if (v > 200000 || v < -200000) v = 0;
            if (noise)
                send_word(PW'($urandom), k == n - 1);
            else if (flip_at >= 0 && k >= flip_at && k < flip_at + flip_len)
                send_word(PW'(v + (flip_at[0] ? FULL_TURN : -FULL_TURN)), k == n - 1);
            else
                send_word(PW'(v), k == n - 1);
        end
        if (n == DEPTH && $urandom_range(0, 1) == 0) begin end
    endtask

    task automatic test_directed();
        send_word(19'sh3FFFF, 1'b1);                   // single word, top of range
        send_word(-19'sd262144, 1'b1);                 // single word, bottom of range
        send_word(-19'sd262144, 1'b0);                 // upward wrap, span fixed to block end
        send_word(19'sd200000, 1'b0);
        send_word(19'sd201000, 1'b1);
        send_word(19'sd10000, 1'b0);                   // downward glitch that reverses
        send_word(-19'sd90000, 1'b0);
        send_word(19'sd12000, 1'b1);
        send_word(19'sd11000, 1'b0);                   // small backward step, then recovery
        send_word(19'sd11500, 1'b0);
        send_word(19'sd30000, 1'b0);
        send_word(19'sd31000, 1'b1);
        send_word(19'sd0, 1'b0);                       // small backward step, then a wrap that does not recover
        send_word(-19'sd80000, 1'b1);
    endtask

    task automatic test_full_block();
        int k;
        for (k = 0; k < DEPTH; k++)                    // closes on depth, no last flag
            send_word(PW'(k * 3000 - 90000 + ((k % 9 == 4) ? FULL_TURN : 0)), 1'b0);
        send_block(DEPTH);                             // last flag on the filling word
    endtask

    task automatic test_limits();
        logic [5:0] lims [4] = '{6'd0, 6'd1, 6'd63, 6'd2};
        int j, b;
        for (j = 0; j < 4; j++) begin
            set_limit(lims[j]);
            for (b = 0; b < 6; b++) send_block($urandom_range(1, 10));
        end
    endtask

    task automatic test_pause();
        send_block(5);
        drain();                                       // hold off until all words return
        send_block(3);
    endtask

    task automatic test_random(int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 29) == 0) n = DEPTH;
            else n = $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0) set_limit(6'($urandom_range(0, 63)));
            if (sent > items * 4 / 5) gaps_on = 1'b0;
            send_block(n);
            sent += n;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_phase_in  <= '0;
        i_is_last   <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        cyc_cnt     = 0;
        err_cnt     = 0;
        fill_cnt    = 0;
        held_phase  = 0;
        limit_reg   = DEPTH - 1;
        gaps_on     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_block();
        gaps_on = 1'b1;
        test_limits();
        test_pause();
        set_limit(6'd63);
        test_random(170);

        drain();
        if (err_cnt == 0)
            $display("phase_unwrap_glitch_smoother: match");
        else
            $display("phase_unwrap_glitch_smoother: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pug_pkg.sv
hdl/pug_div.sv
hdl/pug_dp.sv
hdl/pug_ctrl.sv
hdl/phase_unwrap_glitch_smoother.sv
test/tb_phase_unwrap_glitch_smoother.sv
